// ===== src/led_chain_chase_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// LED chain chase encoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LED_CHAIN_CHASE_ENCODER_UNIT_ASSERT_SVH
`define LED_CHAIN_CHASE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication
`define LCCE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcce assertion failed");

// Next-cycle implication
`define LCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcce assertion failed");

`endif

// ===== src/lcce_pkg.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder package
// Shared constants, register map and types of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lcce_pkg;

  // Chain geometry
  localparam int unsigned CHAIN_LENGTH = 12;
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned STEP_W       = 16;
  localparam int unsigned CNT_W        = $clog2(CHAIN_LENGTH + 1);
  localparam int unsigned IDX_W        = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
  localparam int unsigned DIV_CNT_W    = $clog2(STEP_W);

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RIDX_W = ADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_BLINK_PERIOD  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_ACTIVE_PIXELS = 3'd1;
  localparam logic [RIDX_W-1:0] REG_DIM_SHIFT     = 3'd2;
  localparam logic [RIDX_W-1:0] REG_ZERO_CODE     = 3'd3;
  localparam logic [RIDX_W-1:0] REG_ONE_CODE      = 3'd4;

  localparam logic [7:0] RST_BLINK_PERIOD  = 8'd1;
  localparam logic [3:0] RST_ACTIVE_PIXELS = 4'd12;
  localparam logic [2:0] RST_DIM_SHIFT     = 3'd6;
  localparam logic [7:0] RST_ZERO_CODE     = 8'd31;
  localparam logic [7:0] RST_ONE_CODE      = 8'd61;

  // Byte select within a GRB pixel word
  localparam logic [1:0] SEL_GREEN = 2'd0;
  localparam logic [1:0] SEL_RED   = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [BITS_PER_BYTE-1:0][BYTE_W-1:0] codes_t;

  typedef struct packed {
    logic [7:0] blink_period;
    logic [3:0] active_pixels;
    logic [2:0] dim_shift;
    logic [7:0] zero_code;
    logic [7:0] one_code;
  } cfg_t;

  // One classified step handed from front to back
  typedef struct packed {
    logic   lit;
    pixel_t pixel;
  } item_t;

endpackage

`default_nettype wire

// ===== src/led_chain_chase_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder
// Animation step in, stream of per-byte PWM duty codes out for an LED chain.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one animation step: step
//   index and RGB colour. Output channel (out_valid_o / out_stall_i) gives
//   one transaction per serialized byte (G, R, B per pixel, MSB code on
//   bit7_code_o), then one reset-slot transaction with last_of_frame_o set.
//   Configuration goes through the APB-style port; the user must write it
//   only while idle, since the block does not enforce this.
// Flow:
//   The front end captures a step, runs the bit-serial remainder unit
//   (one step-index bit a cycle) and queues the result; it takes no new
//   step until that result is queued. The back end shifts the chain, then
//   gives three byte slots per active pixel and the reset slot; with a long
//   active chain the back end sets the sustained rate.
// Reset: the chain clears to black, registers take their reset values and
//   both channels go idle. A stalled receiver holds the current result; the
//   two-entry queue then fills and the input stalls in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chain_chase_encoder_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcce_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcce_pkg::DATA_W-1:0]   pwdata,
  output logic [lcce_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Step input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcce_pkg::STEP_W-1:0]   step_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  // Code output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    bit7_code_o,
  output logic [7:0]                    bit6_code_o,
  output logic [7:0]                    bit5_code_o,
  output logic [7:0]                    bit4_code_o,
  output logic [7:0]                    bit3_code_o,
  output logic [7:0]                    bit2_code_o,
  output logic [7:0]                    bit1_code_o,
  output logic [7:0]                    bit0_code_o,
  output logic                          reset_slot_o,
  output logic                          last_of_frame_o
);

  lcce_pkg::cfg_t    cfg;
  lcce_pkg::item_t   push_item;
  lcce_pkg::item_t   pop_item;
  lcce_pkg::codes_t  codes;
  logic              push, pop, full, empty;

  assign pready = 1'b1;

  lcce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  lcce_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .step_index_i (step_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .full_i       (full)
  );

  lcce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  lcce_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .item_i          (pop_item),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .codes_o         (codes),
    .reset_slot_o    (reset_slot_o),
    .last_of_frame_o (last_of_frame_o)
  );

  // Split the code word onto the bit ports, MSB first
  assign bit7_code_o = codes[7];
  assign bit6_code_o = codes[6];
  assign bit5_code_o = codes[5];
  assign bit4_code_o = codes[4];
  assign bit3_code_o = codes[3];
  assign bit2_code_o = codes[2];
  assign bit1_code_o = codes[1];
  assign bit0_code_o = codes[0];

endmodule

`default_nettype wire

// ===== src/lcce_regs.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder register file
// APB-style configuration registers with reset values and read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lcce_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcce_pkg::DATA_W-1:0]   pwdata,
  output logic [lcce_pkg::DATA_W-1:0]   prdata,
  output lcce_pkg::cfg_t                cfg_o
);

  lcce_pkg::cfg_t                  cfg_q;
  logic                            wr_en;
  logic [lcce_pkg::RIDX_W-1:0]     ridx;

  assign wr_en = psel && penable && pwrite;
  assign ridx  = paddr[lcce_pkg::ADDR_W-1:2];

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_period  <= lcce_pkg::RST_BLINK_PERIOD;
      cfg_q.active_pixels <= lcce_pkg::RST_ACTIVE_PIXELS;
      cfg_q.dim_shift     <= lcce_pkg::RST_DIM_SHIFT;
      cfg_q.zero_code     <= lcce_pkg::RST_ZERO_CODE;
      cfg_q.one_code      <= lcce_pkg::RST_ONE_CODE;
    end else if (wr_en) begin
      case (ridx)
        lcce_pkg::REG_BLINK_PERIOD:  cfg_q.blink_period  <= pwdata[7:0];
        lcce_pkg::REG_ACTIVE_PIXELS: cfg_q.active_pixels <= pwdata[3:0];
        lcce_pkg::REG_DIM_SHIFT:     cfg_q.dim_shift     <= pwdata[2:0];
        lcce_pkg::REG_ZERO_CODE:     cfg_q.zero_code     <= pwdata[7:0];
        lcce_pkg::REG_ONE_CODE:      cfg_q.one_code      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (ridx)
      lcce_pkg::REG_BLINK_PERIOD:  prdata[7:0] = cfg_q.blink_period;
      lcce_pkg::REG_ACTIVE_PIXELS: prdata[3:0] = cfg_q.active_pixels;
      lcce_pkg::REG_DIM_SHIFT:     prdata[2:0] = cfg_q.dim_shift;
      lcce_pkg::REG_ZERO_CODE:     prdata[7:0] = cfg_q.zero_code;
      lcce_pkg::REG_ONE_CODE:      prdata[7:0] = cfg_q.one_code;
      default:                     prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/lcce_front.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder front end
// Accepts steps, tests the step index against the blink period with a
// bit-serial remainder unit and hands a classified new pixel to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcce_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcce_pkg::STEP_W-1:0]   step_index_i,
  input  logic [7:0]                    red_i,
  input  logic [7:0]                    green_i,
  input  logic [7:0]                    blue_i,
  output logic                          push_o,
  output lcce_pkg::item_t               push_item_o,
  input  logic                          full_i
);

  typedef enum logic [2:0] {
    FR_IDLE = 3'b001,
    FR_DIV  = 3'b010,
    FR_PUSH = 3'b100
  } front_state_e;

  front_state_e                        state_q, state_d;
  logic [lcce_pkg::STEP_W-1:0]         dividend_q, dividend_d;
  logic [7:0]                          rem_q, rem_d;
  logic [lcce_pkg::DIV_CNT_W-1:0]      bit_cnt_q, bit_cnt_d;
  lcce_pkg::pixel_t                    pixel_q, pixel_d;
  logic [7:0]                          period;
  logic [8:0]                          rem_shift;
  logic [8:0]                          rem_sub;
  logic                                accept;

  assign accept     = in_valid_i && (state_q == FR_IDLE);
  assign in_stall_o = (state_q != FR_IDLE);

  // A zero period counts as one
  assign period    = (cfg_i.blink_period == 8'd0) ? 8'd1 : cfg_i.blink_period;
  assign rem_shift = {rem_q, dividend_q[lcce_pkg::STEP_W-1]};
  assign rem_sub   = rem_shift - {1'b0, period};

  // Hand off the classified pixel
  assign push_o            = (state_q == FR_PUSH) && !full_i;
  assign push_item_o.lit   = (rem_q == 8'd0);
  assign push_item_o.pixel = (rem_q == 8'd0) ? pixel_q : '0;

  // Sequence: capture, one remainder bit per cycle, push
  always_comb begin
    state_d    = state_q;
    dividend_d = dividend_q;
    rem_d      = rem_q;
    bit_cnt_d  = bit_cnt_q;
    pixel_d    = pixel_q;
    case (state_q)
      FR_IDLE: begin
        if (accept) begin
          dividend_d = step_index_i;
          rem_d      = '0;
          bit_cnt_d  = '0;
          pixel_d    = {green_i >> cfg_i.dim_shift, red_i >> cfg_i.dim_shift,
                        blue_i >> cfg_i.dim_shift};
          state_d    = FR_DIV;
        end
      end
      FR_DIV: begin
        rem_d      = (rem_shift >= {1'b0, period}) ? rem_sub[7:0] : rem_shift[7:0];
        dividend_d = {dividend_q[lcce_pkg::STEP_W-2:0], 1'b0};
        bit_cnt_d  = bit_cnt_q + lcce_pkg::DIV_CNT_W'(1);
        if (bit_cnt_q == lcce_pkg::DIV_CNT_W'(lcce_pkg::STEP_W - 1)) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    rem_q      <= rem_d;
    bit_cnt_q  <= bit_cnt_d;
    pixel_q    <= pixel_d;
  end

endmodule

`default_nettype wire

// ===== src/lcce_queue.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder step queue
// Short flop-based FIFO of classified steps between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcce_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lcce_pkg::item_t  push_item_i,
  output logic             full_o,
  input  logic             pop_i,
  output lcce_pkg::item_t  pop_item_o,
  output logic             empty_o
);

  lcce_pkg::item_t                  entry_q [lcce_pkg::QUEUE_DEPTH];
  logic [lcce_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [lcce_pkg::QCNT_W-1:0]      fill_q;
  logic                             do_push, do_pop;

  assign full_o     = (fill_q == lcce_pkg::QCNT_W'(lcce_pkg::QUEUE_DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == lcce_pkg::QPTR_W'(lcce_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + lcce_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == lcce_pkg::QPTR_W'(lcce_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + lcce_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + lcce_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - lcce_pkg::QCNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/lcce_back.sv =====
// ----------------------------------------------------------------------------
// LED chain chase encoder back end
// Shifts the pixel chain per step and serializes the active pixels byte by
// byte into duty codes, followed by the reset slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_chain_chase_encoder_unit_assert.svh"

module lcce_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcce_pkg::cfg_t       cfg_i,
  input  lcce_pkg::item_t      item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcce_pkg::codes_t     codes_o,
  output logic                 reset_slot_o,
  output logic                 last_of_frame_o
);

  typedef enum logic [2:0] {
    BK_IDLE  = 3'b001,
    BK_BYTE  = 3'b010,
    BK_RSLOT = 3'b100
  } back_state_e;

  back_state_e                      state_q, state_d;
  lcce_pkg::pixel_t                 chain_q [lcce_pkg::CHAIN_LENGTH];
  logic [lcce_pkg::IDX_W-1:0]       pix_q, pix_d;
  logic [1:0]                       sel_q, sel_d;
  logic                             lit_q, lit_d;
  logic [lcce_pkg::CNT_W-1:0]       count;
  lcce_pkg::pixel_t                 cur_pixel;
  logic [lcce_pkg::BYTE_W-1:0]      cur_byte;
  logic                             out_free;
  logic                             last_pixel;

  logic                             out_valid_q, out_valid_d;
  lcce_pkg::codes_t                 codes_q, codes_d;
  logic                             rslot_q, rslot_d;
  logic                             last_q, last_d;

  // Saturate the active pixel count to the chain length
  assign count = (int'(cfg_i.active_pixels) > lcce_pkg::CHAIN_LENGTH) ?
                 lcce_pkg::CNT_W'(lcce_pkg::CHAIN_LENGTH) :
                 lcce_pkg::CNT_W'(cfg_i.active_pixels);

  assign pop_o      = (state_q == BK_IDLE) && !empty_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_pixel  = chain_q[pix_q];
  assign last_pixel = (lcce_pkg::CNT_W'(pix_q) + lcce_pkg::CNT_W'(1)) == count;

  // Pick the byte in G, R, B order
  always_comb begin
    case (sel_q)
      lcce_pkg::SEL_GREEN: cur_byte = cur_pixel[23:16];
      lcce_pkg::SEL_RED:   cur_byte = cur_pixel[15:8];
      default:             cur_byte = cur_pixel[7:0];
    endcase
  end

  // Serialize: one result per free output slot
  always_comb begin
    state_d     = state_q;
    pix_d       = pix_q;
    sel_d       = sel_q;
    lit_d       = lit_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    codes_d     = codes_q;
    rslot_d     = rslot_q;
    last_d      = last_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          lit_d   = item_i.lit;
          pix_d   = '0;
          sel_d   = lcce_pkg::SEL_GREEN;
          state_d = (count == '0) ? BK_RSLOT : BK_BYTE;
        end
      end
      BK_BYTE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rslot_d     = 1'b0;
          last_d      = 1'b0;
          for (int b = 0; b < lcce_pkg::BITS_PER_BYTE; b++) begin
            codes_d[b] = (lit_q && cur_byte[b]) ? cfg_i.one_code : cfg_i.zero_code;
          end
          if (sel_q == lcce_pkg::SEL_BLUE) begin
            sel_d = lcce_pkg::SEL_GREEN;
            pix_d = pix_q + lcce_pkg::IDX_W'(1);
            if (last_pixel) begin
              state_d = BK_RSLOT;
            end
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end
      BK_RSLOT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          codes_d     = '0;
          rslot_d     = 1'b1;
          last_d      = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control and chain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lcce_pkg::CHAIN_LENGTH; i++) begin
        chain_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        for (int i = lcce_pkg::CHAIN_LENGTH - 1; i > 0; i--) begin
          chain_q[i] <= chain_q[i-1];
        end
        chain_q[0] <= item_i.pixel;
      end
    end
  end

  // Walk counters and output payload
  always_ff @(posedge clk_i) begin
    pix_q   <= pix_d;
    sel_q   <= sel_d;
    lit_q   <= lit_d;
    codes_q <= codes_d;
    rslot_q <= rslot_d;
    last_q  <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign codes_o         = codes_q;
  assign reset_slot_o    = rslot_q;
  assign last_of_frame_o = last_q;

  // Checks
  `LCCE_ASSERT_SAME(a_rslot_codes_zero, clk_i, rst_ni, out_valid_q && rslot_q, codes_q == '0)
  `LCCE_ASSERT_SAME(a_last_is_rslot, clk_i, rst_ni, out_valid_q, last_q == rslot_q)
  `LCCE_ASSERT_SAME(a_pix_in_range, clk_i, rst_ni, state_q == BK_BYTE, lcce_pkg::CNT_W'(pix_q) < count)
  `LCCE_ASSERT_NEXT(a_rslot_to_idle, clk_i, rst_ni, state_q == BK_RSLOT && out_free, state_q == BK_IDLE)

endmodule

`default_nettype wire

// ===== tb/lcce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain chase encoder checker
// Watches the configuration port and both channels of the encoder. Keeps its
// own pixel chain and register copy, encodes every accepted step into the
// duty code slots it must produce, and compares each delivered slot with the
// oldest one waiting. Reports the mismatch count and the number of slots
// still owed.
// ----------------------------------------------------------------------------

module lcce_checker
  import lcce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  // Step channel
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [STEP_W-1:0] step_index_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  // Code channel
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        bit7_code_i,
  input  logic [7:0]        bit6_code_i,
  input  logic [7:0]        bit5_code_i,
  input  logic [7:0]        bit4_code_i,
  input  logic [7:0]        bit3_code_i,
  input  logic [7:0]        bit2_code_i,
  input  logic [7:0]        bit1_code_i,
  input  logic [7:0]        bit0_code_i,
  input  logic              reset_slot_i,
  input  logic              last_of_frame_i,
  // Status
  output int                mismatch_count_o,
  output int                slots_pending_o
);

  typedef struct packed {
    logic [7:0][7:0] codes;  // codes[7] is the MSB duty code
    logic            reset_slot;
    logic            last_of_frame;
  } code_slot_t;

  code_slot_t frame_slots[$];
  pixel_t     chain [CHAIN_LENGTH];
  cfg_t       cfg;

  // Shift the chain, load the new pixel and queue the slots of one step
  task automatic encode_step(input logic [STEP_W-1:0] step, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b);
    logic [7:0]  period;
    logic        lit;
    int unsigned count;
    logic [7:0]  grb_byte;
    code_slot_t  slot;
    int          i;
    int          j;
    int          k;
    period = (cfg.blink_period == 8'd0) ? 8'd1 : cfg.blink_period;
    lit    = (step % period) == 0;
    count  = (cfg.active_pixels > CHAIN_LENGTH) ? CHAIN_LENGTH : cfg.active_pixels;
    for (i = CHAIN_LENGTH - 1; i > 0; i--) chain[i] = chain[i-1];
    if (!lit) begin
      r = '0;
      g = '0;
      b = '0;
    end
    chain[0] = {g >> cfg.dim_shift, r >> cfg.dim_shift, b >> cfg.dim_shift};
    // One slot per byte, G then R then B
    for (i = 0; i < int'(count); i++) begin
      for (j = 2; j >= 0; j--) begin
        grb_byte = chain[i][8*j +: 8];
        for (k = 0; k < 8; k++) begin
          slot.codes[k] = (lit && grb_byte[k]) ? cfg.one_code : cfg.zero_code;
        end
        slot.reset_slot    = 1'b0;
        slot.last_of_frame = 1'b0;
        frame_slots.push_back(slot);
      end
    end
    // Trailing reset slot closes the frame
    slot.codes         = '0;
    slot.reset_slot    = 1'b1;
    slot.last_of_frame = 1'b1;
    frame_slots.push_back(slot);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    code_slot_t want;
    code_slot_t got;
    int         k;
    if (!rst_ni) begin
      for (k = 0; k < CHAIN_LENGTH; k++) chain[k] = '0;
      cfg.blink_period  = RST_BLINK_PERIOD;
      cfg.active_pixels = RST_ACTIVE_PIXELS;
      cfg.dim_shift     = RST_DIM_SHIFT;
      cfg.zero_code     = RST_ZERO_CODE;
      cfg.one_code      = RST_ONE_CODE;
      frame_slots.delete();
      mismatch_count_o = 0;
      slots_pending_o  = 0;
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_BLINK_PERIOD:  cfg.blink_period  = pwdata[7:0];
          REG_ACTIVE_PIXELS: cfg.active_pixels = pwdata[3:0];
          REG_DIM_SHIFT:     cfg.dim_shift     = pwdata[2:0];
          REG_ZERO_CODE:     cfg.zero_code     = pwdata[7:0];
          REG_ONE_CODE:      cfg.one_code      = pwdata[7:0];
          default: ;
        endcase
      end
      // Compare a delivered slot with the oldest one owed
      if (out_valid_i && !out_stall_i) begin
        got.codes = {bit7_code_i, bit6_code_i, bit5_code_i, bit4_code_i,
                     bit3_code_i, bit2_code_i, bit1_code_i, bit0_code_i};
        got.reset_slot    = reset_slot_i;
        got.last_of_frame = last_of_frame_i;
        if (frame_slots.size() == 0) begin
          $error("code transaction with no slot owed");
          mismatch_count_o++;
        end else begin
          want = frame_slots.pop_front();
          for (k = 7; k >= 0; k--) begin
            if (got.codes[k] !== want.codes[k]) begin
              $error("bit%0d_code mismatch: expected %0d, actual %0d",
                     k, want.codes[k], got.codes[k]);
              mismatch_count_o++;
            end
          end
          if (got.reset_slot !== want.reset_slot) begin
            $error("reset_slot mismatch: expected %0d, actual %0d",
                   want.reset_slot, got.reset_slot);
            mismatch_count_o++;
          end
          if (got.last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame mismatch: expected %0d, actual %0d",
                   want.last_of_frame, got.last_of_frame);
            mismatch_count_o++;
          end
        end
      end
      // Encode an accepted step
      if (in_valid_i && !in_stall_i) begin
        encode_step(step_index_i, red_i, green_i, blue_i);
      end
      slots_pending_o = frame_slots.size();
    end
  end

endmodule

// ===== tb/led_chain_chase_encoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain chase encoder testbench
// Drives animation steps and register settings into the encoder: a directed
// run over field extremes, blanked steps, a zero blink period and saturated
// or empty pixel counts, then random phases under several idle and stall
// patterns. The checker beside the block predicts and compares every slot.
// ----------------------------------------------------------------------------

module led_chain_chase_encoder_unit_tb;
  import lcce_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_STEPS    = 52;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [STEP_W-1:0] step_index_i = '0;
  logic [7:0]        red_i = '0;
  logic [7:0]        green_i = '0;
  logic [7:0]        blue_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [7:0]        bit7_code_o, bit6_code_o, bit5_code_o, bit4_code_o;
  logic [7:0]        bit3_code_o, bit2_code_o, bit1_code_o, bit0_code_o;
  logic              reset_slot_o;
  logic              last_of_frame_o;

  int                mismatches;
  int                slots_pending;
  int unsigned       send_gap_pct = 0;
  int unsigned       stall_pct = 0;
  int unsigned       quiet_cycles = 0;

  led_chain_chase_encoder_unit i_dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .step_index_i, .red_i, .green_i, .blue_i,
    .out_valid_o, .out_stall_i,
    .bit7_code_o, .bit6_code_o, .bit5_code_o, .bit4_code_o,
    .bit3_code_o, .bit2_code_o, .bit1_code_o, .bit0_code_o,
    .reset_slot_o, .last_of_frame_o
  );

  lcce_checker i_checker (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_stall_i(in_stall_o), .step_index_i, .red_i, .green_i, .blue_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .bit7_code_i(bit7_code_o), .bit6_code_i(bit6_code_o),
    .bit5_code_i(bit5_code_o), .bit4_code_i(bit4_code_o),
    .bit3_code_i(bit3_code_o), .bit2_code_i(bit2_code_o),
    .bit1_code_i(bit1_code_o), .bit0_code_i(bit0_code_o),
    .reset_slot_i(reset_slot_o), .last_of_frame_i(last_of_frame_o),
    .mismatch_count_o(mismatches), .slots_pending_o(slots_pending)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Random receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Present one step, with random sender gaps, and hold it until accepted
  task automatic send_step(input logic [STEP_W-1:0] step, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    step_index_i <= step;
    red_i        <= r;
    green_i      <= g;
    blue_i       <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every owed slot has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (slots_pending != 0);
    @(posedge clk_i);
  endtask

  // Setup and access cycle; psel stays high so writes can run back to back
  task automatic apb_write(input logic [RIDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  // Write every register once the block is idle
  task automatic set_config(input logic [7:0] period, input logic [3:0] pixels,
                            input logic [2:0] shift, input logic [7:0] zero_dc,
                            input logic [7:0] one_dc);
    wait_drained();
    apb_write(REG_BLINK_PERIOD, DATA_W'(period));
    apb_write(REG_ACTIVE_PIXELS, DATA_W'(pixels));
    apb_write(REG_DIM_SHIFT, DATA_W'(shift));
    apb_write(REG_ZERO_CODE, DATA_W'(zero_dc));
    apb_write(REG_ONE_CODE, DATA_W'(one_dc));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [7:0]  period;
    logic [3:0]  pixels;
    logic [2:0]  shift;
    int unsigned period_eff;
    logic [STEP_W-1:0] step;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: heavy dimming
    send_step(16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_step(16'd1, 8'hC0, 8'h80, 8'h40);

    // No dimming, full-swing codes
    set_config(8'd1, 4'd12, 3'd0, 8'd0, 8'd255);
    send_step(16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'hFFFF, 8'h00, 8'h00, 8'h00);
    send_step(16'd2, 8'hAA, 8'h55, 8'hAA);
    send_step(16'd3, 8'h55, 8'hAA, 8'h55);
    send_step(16'd4, 8'h01, 8'h80, 8'hFE);
    send_step(16'd5, 8'h7F, 8'h01, 8'hFF);

    // Blanked steps, pixel count above the chain length
    set_config(8'd3, 4'd15, 3'd0, 8'hAA, 8'h55);
    send_step(16'd0, 8'hFF, 8'h0F, 8'hF0);
    send_step(16'd1, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'd2, 8'h81, 8'h42, 8'h24);
    send_step(16'd3, 8'h3C, 8'hC3, 8'h99);
    send_step(16'd4, 8'hFF, 8'hFF, 8'hFF);

    // Zero blink period, no active pixels, maximum shift
    set_config(8'd0, 4'd0, 3'd7, 8'd255, 8'd0);
    send_step(16'd7, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'hFFFF, 8'h80, 8'h80, 8'h80);
    send_step(16'd0, 8'h7F, 8'h7F, 8'h7F);

    // Largest blink period, single pixel
    set_config(8'd255, 4'd1, 3'd3, 8'd0, 8'd255);
    send_step(16'd255, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'd254, 8'hFF, 8'hFF, 8'hFF);
    send_step(16'd510, 8'hF8, 8'h08, 8'h80);
    send_step(16'd0, 8'h88, 8'h44, 8'h22);

    // Random phases over the idle and stall patterns
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(5))
        0:       period = 8'd0;
        1:       period = 8'd1;
        2:       period = 8'($urandom_range(2, 4));
        3:       period = 8'd255;
        default: period = 8'($urandom_range(255));
      endcase
      pixels = 4'($urandom_range(15));
      shift  = (ph % 2 == 0) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
      set_config(period, pixels, shift, 8'($urandom_range(255)), 8'($urandom_range(255)));
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 48; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 48; end
        default: begin send_gap_pct = 22; stall_pct = 22; end
      endcase
      period_eff = (period == 8'd0) ? 1 : period;
      for (int n = 0; n < PHASE_STEPS; n++) begin
        // Let the chain drain completely once, midway through phase 1
        if (ph == 1 && n == PHASE_STEPS / 2) wait_drained();
        // Mostly lit steps, the rest any index
        if ($urandom_range(3) != 0) begin
          step = STEP_W'(period_eff * $urandom_range(65535 / period_eff));
        end else begin
          step = STEP_W'($urandom_range(65535));
        end
        send_step(step, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end
    end

    // Drain and settle
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && slots_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/lcce_pkg.sv
src/lcce_regs.sv
src/lcce_front.sv
src/lcce_queue.sv
src/lcce_back.sv
src/led_chain_chase_encoder_unit.sv
tb/lcce_checker.sv
tb/led_chain_chase_encoder_unit_tb.sv
